FILE: hdl/lat_pkg.sv
// shared constants, codes and types of the line assembler
// no dependencies; imported by lat_idle and the top level
package lat_pkg;

  localparam int MAX_LINE = 64;
  localparam int CNT_W    = $clog2(MAX_LINE);
  localparam int CAP_W    = 7;
  localparam int TMO_W    = 32;
  localparam int CHAR_W   = 8;
  localparam int POS_W    = 6;
  localparam int STAT_W   = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_DATA_W = ((CHAR_W + 2 * POS_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'd1;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [STAT_W-1:0] STAT_LINE     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_TOO_LONG = 2'd1;
  localparam logic [STAT_W-1:0] STAT_TIMEOUT  = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_NL = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0D;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_LINE);
  localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(MAX_LINE);

  // control from the main sequencer to the idle timer
  typedef struct packed {
    logic tick;     // one tick item accepted
    logic restart;  // stored or dropped data byte, or newline
  } idle_ctl_t;

endpackage

FILE: hdl/lat_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module lat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/lat_idle.sv
// idle tick counter with saturation and timeout compare
// depends on lat_pkg
module lat_idle
  import lat_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  idle_ctl_t        ctl,
  input  logic [TMO_W-1:0] timeout_ticks,
  output logic             hit
);

  logic [TMO_W-1:0] idle;
  logic [TMO_W-1:0] idle_inc;

  // saturate at all ones
  assign idle_inc = (idle == {TMO_W{1'b1}}) ? idle : idle + TMO_W'(1);
  assign hit = ctl.tick && (timeout_ticks != '0) && (idle_inc >= timeout_ticks);

  always_ff @(posedge clk) begin
    if (rst) begin
      idle <= '0;
    end else if (hit || ctl.restart) begin
      idle <= '0;
    end else if (ctl.tick) begin
      idle <= idle_inc;
    end
  end

endmodule

FILE: hdl/line_assembler_with_timeout.sv
// top level of the line assembler: line store, sequencer and output register
// depends on lat_pkg, lat_ram and lat_idle
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser: cmd, tdata: rx_byte
//  m_*      out  m_tvalid/m_tready  tuser: status, tdata: char/pos/len, tlast: last
//  cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// a single result (empty, too long, timeout) is loaded into the output register
// in the same cycle that its byte or tick is taken, or at the edge that frees
// the register. a line of n characters is read out of the store at one
// character per cycle while the output is not stalled, paced by the ram read
// port. input is held off while a readout or a pending result is in progress.
// reset is synchronous; the line store needs no clearing pass.
module line_assembler_with_timeout
  import lat_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [CHAR_W-1:0]     s_tdata,   // [7:0] rx_byte
  input  logic                  s_tuser,   // [0] cmd
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] char_value, [13:8] char_position,
                                           // [19:14] line_length, rest zero
  output logic [STAT_W-1:0]     m_tuser,   // [1:0] status
  output logic                  m_tlast,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PEND,  // single result waiting for the output register
    ST_READ   // walking the line store
  } state_t;

  state_t state;

  // configuration registers
  logic [CAP_W-1:0] line_capacity;
  logic [TMO_W-1:0] timeout_ticks;

  // line state
  logic [CNT_W-1:0] count;
  logic             overflow;
  logic [CNT_W-1:0] run_len;
  logic [CNT_W-1:0] rd_pos;
  logic [STAT_W-1:0] pend_status;

  // ram
  logic              ram_we;
  logic              ram_re;
  logic [CNT_W-1:0]  ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  // decode of the accepted transaction
  logic             accept;
  logic             is_tick;
  logic             is_nl;
  logic             is_cr;
  logic             data_byte;
  logic             nl_accept;
  logic             run_start;
  logic             store_ok;
  logic [CAP_W-1:0] cap;
  logic             tmo_hit;
  logic             single;
  logic [STAT_W-1:0] single_status;
  logic             out_free;
  logic             out_load;
  logic             rd_last;
  idle_ctl_t        idle_ctl;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign is_tick   = (s_tuser == CMD_TICK);
  assign is_nl     = (s_tdata == CHAR_NL);
  assign is_cr     = (s_tdata == CHAR_CR);
  assign data_byte = accept && !is_tick && !is_nl && !is_cr;
  assign nl_accept = accept && !is_tick && is_nl;
  assign run_start = nl_accept && !overflow && (count != '0);

  // capacity above the store size acts as the store size
  assign cap      = (line_capacity > CAP_MAX) ? CAP_MAX : line_capacity;
  assign store_ok = ((CAP_W'(count) + CAP_W'(1)) < cap);

  assign idle_ctl.tick    = accept && is_tick;
  assign idle_ctl.restart = data_byte || nl_accept;

  lat_idle u_idle (
    .clk           (clk),
    .rst           (rst),
    .ctl           (idle_ctl),
    .timeout_ticks (timeout_ticks),
    .hit           (tmo_hit)
  );

  // single-result transactions: timeout, too long, empty line
  assign single = tmo_hit || (nl_accept && !run_start);
  always_comb begin
    if (tmo_hit) begin
      single_status = STAT_TIMEOUT;
    end else if (overflow) begin
      single_status = STAT_TOO_LONG;
    end else begin
      single_status = STAT_LINE;
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign rd_last  = (rd_pos == run_len - CNT_W'(1));

  // output register takes a new result this cycle
  assign out_load = out_free && (((state == ST_IDLE) && single) ||
                                 (state == ST_PEND) || (state == ST_READ));

  // first read at the newline, then one read per character handed out but the last
  assign ram_we = data_byte && store_ok;
  assign ram_re = run_start || ((state == ST_READ) && out_free && !rd_last);
  assign ram_raddr = run_start ? '0 : rd_pos + CNT_W'(1);

  lat_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_LINE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count),
    .wdata (s_tdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      line_capacity <= CAP_RESET;
      timeout_ticks <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LINE_CAPACITY: line_capacity <= cfg_data[CAP_W-1:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // line state: every result clears the line when its transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (nl_accept || tmo_hit) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (data_byte) begin
      if (store_ok) begin
        count <= count + CNT_W'(1);
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (run_start) begin
            run_len <= count;
            rd_pos  <= '0;
            state   <= ST_READ;
          end else if (single) begin
            if (out_free) begin
              m_tvalid <= 1'b1;
              m_tuser  <= single_status;
              m_tdata  <= '0;
              m_tlast  <= 1'b1;
            end else begin
              pend_status <= single_status;
              state       <= ST_PEND;
            end
          end
        end
        ST_PEND: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= pend_status;
            m_tdata  <= '0;
            m_tlast  <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        ST_READ: begin
          // ram_rdata holds store[rd_pos] until the next read is issued
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= STAT_LINE;
            m_tdata  <= OUT_DATA_W'({POS_W'(run_len), POS_W'(rd_pos), ram_rdata});
            m_tlast  <= rd_last;
            if (rd_last) begin
              state <= ST_IDLE;
            end else begin
              rd_pos <= rd_pos + CNT_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
